[sv/mipmap_box_downsampler_defines.svh]
// assertion helpers for the mip chain generator
`ifndef MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH

// property that must hold at every edge out of reset
`define MBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mbd_pkg.sv]
`default_nettype none
package mbd_pkg;
    localparam int MAX_DIM    = 4096;
    localparam int MAX_LEVELS = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [3:0]  level;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [7:0]  alpha_out;
        logic        last;
        logic        chain_done;
    } t_pix_out;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input pixel, start at level 0
        logic step;     // run one level (memory read issued)
        logic finish;   // completes the level step: counters advance, line store written on a row step
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic produced;  // level step made a result
        logic more;      // a further level exists
    } t_sts;
endpackage
`default_nettype wire

[sv/mbd_stream_if.sv]
`default_nettype none
interface mbd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/mbd_ctrl.sv]
`default_nettype none
module mbd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_out_free,
    input  wire logic           i_cfg_we,
    input  wire mbd_pkg::t_sts  i_sts,
    output mbd_pkg::t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = (r_state == ST_IDLE) && !i_cfg_we;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.step = 1'b1;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (i_sts.produced) n_state = ST_EMIT;
                else begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = i_sts.more ? ST_RD : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

`include "mipmap_box_downsampler_defines.svh"
    `MBD_ASSERT(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `MBD_ASSERT_NEXT(a_load_rd, i_clk, i_rst_n, o_cmd.load, r_state == ST_RD, "load without read")
    `MBD_ASSERT(a_ready_idle, i_clk, i_rst_n, !o_in_ready || r_state == ST_IDLE, "ready while busy")
endmodule
`default_nettype wire

[sv/mbd_datapath.sv]
`default_nettype none
module mbd_datapath #(
    parameter int MAX_DIM    = mbd_pkg::MAX_DIM,
    parameter int MAX_LEVELS = mbd_pkg::MAX_LEVELS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mbd_pkg::t_cmd                    i_cmd,
    input  wire mbd_pkg::t_pix_in                 i_pix,
    input  wire logic                             i_cfg_we,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mbd_pkg::CFG_W-1:0]        i_cfg_data,
    output mbd_pkg::t_sts                         o_sts,
    output mbd_pkg::t_pix_out                     o_res
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int NL = MAX_LEVELS + 1;

    logic [mbd_pkg::CFG_W-1:0] r_bw, r_bh;
    logic [DW-1:0] r_lw [NL];
    logic [DW-1:0] r_lh [NL];
    logic [DW-1:0] r_off [NL];
    logic [LW-1:0] r_cnt;
    logic [DW-1:0] r_col [NL];
    logic [DW-1:0] r_row [NL];
    logic [31:0]   r_held [NL];
    logic [LW-1:0] r_s;
    logic [9:0]    r_ch [4];
    logic          r_prod;
    logic [35:0]   r_mem [MAX_DIM];
    logic [35:0]   r_rd;
    logic          r_plan_pend;

    // clamped sizes of the written registers
    function automatic logic [DW-1:0] clampd(input logic [mbd_pkg::CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0) r = DW'(1);
        else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
        else r = DW'(v);
        return r;
    endfunction

    // whether a level step at the given source position makes a result
    function automatic logic lvl_prod(input logic [DW-1:0] a_sw, input logic [DW-1:0] a_sh,
                                      input logic [DW-1:0] a_dw, input logic [DW-1:0] a_dh,
                                      input logic [DW-1:0] a_x, input logic [DW-1:0] a_y);
        logic l_w2, l_h2, l_sx, l_sy;
        l_w2 = a_sw >= DW'(2);
        l_h2 = a_sh >= DW'(2);
        l_sx = l_w2 && ({1'b0, a_x} >= {a_dw, 1'b0});
        l_sy = l_h2 && ({1'b0, a_y} >= {a_dh, 1'b0});
        return !l_sx && !(l_w2 && !a_x[0]) && !l_sy && !(l_h2 && !a_y[0]);
    endfunction

    // level plan, rebuilt in the cycle after a register write
    logic [DW-1:0] n_lw [NL];
    logic [DW-1:0] n_lh [NL];
    logic [DW-1:0] n_off [NL];
    logic [LW-1:0] n_cnt;
    always_comb begin
        n_lw[0] = clampd(r_bw);
        n_lh[0] = clampd(r_bh);
        n_off[0] = '0;
        n_cnt = '0;
        for (int k = 1; k < NL; k++) begin
            n_lw[k] = (n_lw[k-1] > DW'(1)) ? (n_lw[k-1] >> 1) : DW'(1);
            n_lh[k] = (n_lh[k-1] > DW'(1)) ? (n_lh[k-1] >> 1) : DW'(1);
            n_off[k] = (k == 1) ? '0 : DW'(n_off[k-1] + n_lw[k-1]);
            if ((n_lw[k-1] > DW'(1) || n_lh[k-1] > DW'(1)) && n_cnt == LW'(k-1))
                n_cnt = LW'(k);
        end
    end

    // current level step decode
    logic [DW-1:0] sw, sh, dw, dh, x, y, idx;
    logic          w2, h2, skip_x, hold, skip_y, wr_row, prod;
    logic [9:0]    hs [4];
    always_comb begin
        sw = r_lw[r_s]; sh = r_lh[r_s];
        dw = r_lw[LW'(r_s + 1'b1)]; dh = r_lh[LW'(r_s + 1'b1)];
        x = r_col[r_s]; y = r_row[r_s];
        w2 = sw >= DW'(2); h2 = sh >= DW'(2);
        skip_x = w2 && ({1'b0, x} >= {dw, 1'b0});
        hold = w2 && !skip_x && !x[0];
        skip_y = h2 && ({1'b0, y} >= {dh, 1'b0});
        idx = DW'(r_off[LW'(r_s + 1'b1)] + (x >> 1));
        wr_row = !skip_x && !hold && h2 && !skip_y && !y[0];
        prod = !skip_x && !hold && !skip_y && !wr_row;
        for (int i = 0; i < 4; i++)
            hs[i] = w2 ? 10'(r_held[r_s][8*i +: 8]) + r_ch[i] : r_ch[i];
    end

    // next level decode, from its own counters
    logic [LW-1:0] s1, s2;
    logic          prod_next;
    always_comb begin
        s1 = LW'(r_s + 1'b1);
        s2 = (s1 < LW'(MAX_LEVELS)) ? LW'(s1 + 1'b1) : s1;
        prod_next = lvl_prod(r_lw[s1], r_lh[s1], r_lw[s2], r_lh[s2], r_col[s1], r_row[s1]);
    end

    // rounded means
    logic [10:0] fs [4];
    logic [7:0]  avg [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fs[i] = 11'(hs[i]) + (h2 ? 11'(r_rd[9*i +: 9]) : 11'd0);
            if (w2 && h2) avg[i] = 8'((fs[i] + 11'd2) >> 2);
            else if (w2 || h2) avg[i] = 8'((fs[i] + 11'd1) >> 1);
            else avg[i] = fs[i][7:0];
        end
    end

    // line store, one port
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) r_rd <= r_mem[idx[AW-1:0]];
        if (i_cmd.finish && wr_row && 32'(idx) < MAX_DIM)
            r_mem[idx[AW-1:0]] <= {hs[3][8:0], hs[2][8:0], hs[1][8:0], hs[0][8:0]};
    end

    // registers, plan and level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= mbd_pkg::CFG_W'(1); r_bh <= mbd_pkg::CFG_W'(1);
            r_plan_pend <= 1'b1; r_s <= '0; r_prod <= 1'b0;
            r_cnt <= '0;
            for (int k = 0; k < NL; k++) begin
                r_col[k] <= '0; r_row[k] <= '0; r_held[k] <= '0;
            end
        end else begin
            r_plan_pend <= i_cfg_we;
            if (i_cfg_we) begin
                if (i_cfg_idx == mbd_pkg::REG_BASE_WIDTH) r_bw <= i_cfg_data;
                else r_bh <= i_cfg_data;
            end
            if (r_plan_pend) begin
                r_lw <= n_lw; r_lh <= n_lh; r_off <= n_off; r_cnt <= n_cnt;
                for (int k = 0; k < NL; k++) begin
                    r_col[k] <= '0; r_row[k] <= '0;
                end
            end
            if (i_cmd.load) begin
                r_ch[0] <= 10'(i_pix.red_in);  r_ch[1] <= 10'(i_pix.green_in);
                r_ch[2] <= 10'(i_pix.blue_in); r_ch[3] <= 10'(i_pix.alpha_in);
                r_s <= '0;
            end
            if (i_cmd.step) r_prod <= prod && (r_s < r_cnt);
            if (i_cmd.finish && r_s < r_cnt) begin
                if (x + DW'(1) >= sw) begin
                    r_col[r_s] <= '0;
                    r_row[r_s] <= (y + DW'(1) >= sh) ? '0 : DW'(y + 1'b1);
                end else r_col[r_s] <= DW'(x + 1'b1);
                if (hold) r_held[r_s] <= {r_ch[3][7:0], r_ch[2][7:0], r_ch[1][7:0], r_ch[0][7:0]};
                if (prod) begin
                    for (int i = 0; i < 4; i++) r_ch[i] <= 10'(avg[i]);
                    r_s <= LW'(r_s + 1'b1);
                end
            end
        end
    end

    // result and status
    logic more;
    assign more = LW'(r_s + 1'b1) < r_cnt;
    always_comb begin
        o_sts.produced = r_prod;
        o_sts.more = more;
        o_res.level = 4'(r_s + 1'b1);
        o_res.pos_x = 11'(x >> 1);
        o_res.pos_y = 11'(y >> 1);
        o_res.red_out = avg[0]; o_res.green_out = avg[1];
        o_res.blue_out = avg[2]; o_res.alpha_out = avg[3];
        // next level makes no result if it is not built or its counters skip, hold or store a row
        o_res.last = !(more && prod_next);
        o_res.chain_done = !more && (LW'(r_s + 1'b1) == r_cnt) &&
            (DW'((x >> 1) + 1'b1) == dw) && (DW'((y >> 1) + 1'b1) == dh);
    end
endmodule
`default_nettype wire

[sv/mipmap_box_downsampler.sv]
// an input transfer loads the pixel; each level step passes the read and calc
//   states and, when it produces, the emit state, which waits for a free output
//   register, so output stalls hold the step; the line store has a single port
// results leave through an output register; one pixel is in flight at a time
// reset: synchronous active low; sizes return to 1x1, counters and held pixels clear,
//   line store contents stay undefined until written
`default_nettype none
module mipmap_box_downsampler #(
    parameter int MAX_DIM    = mbd_pkg::MAX_DIM,
    parameter int MAX_LEVELS = mbd_pkg::MAX_LEVELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mbd_stream_if.sink                         s_in,
    mbd_stream_if.source                       m_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mbd_pkg::CFG_W-1:0]     i_cfg_data
);
    mbd_pkg::t_cmd     w_cmd;
    mbd_pkg::t_sts     w_sts;
    mbd_pkg::t_pix_out w_res;
    mbd_pkg::t_pix_out r_out;
    logic              r_ov;
    logic              w_free;

    // result register, free when empty or taken this cycle
    assign w_free = !r_ov || m_out.ready;

    mbd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .i_out_free(w_free), .i_cfg_we(i_cfg_we),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    mbd_datapath #(.MAX_DIM(MAX_DIM), .MAX_LEVELS(MAX_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_pix(s_in.data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_sts(w_sts), .o_res(w_res)
    );

    // push a result whenever the emit step completes
    logic w_push;
    assign w_push = w_cmd.finish && w_sts.produced;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_push) r_ov <= 1'b1;
        else if (m_out.ready) r_ov <= 1'b0;
        if (w_push) r_out <= w_res;
    end
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire
